>>> rtl/fnls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnls_pkg: shared types and constants of the loop-control stack
// Widths, request and status codes, item structs and the cell control word.
// ----------------------------------------------------------------------------
package fnls_pkg;

  localparam int LOOP_DEPTH = 16;
  localparam int VAR_BITS   = 8;
  localparam int ADDR_BITS  = 16;
  localparam int VALUE_BITS = 32;
  localparam int POS_BITS   = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
  localparam int CNT_BITS   = $clog2(LOOP_DEPTH + 1);
  localparam int OUT_CNT_BITS = 5;

  typedef enum logic [1:0] {
    REQ_FOR      = 2'd0,
    REQ_NEXT_TOP = 2'd1,
    REQ_NEXT_VAR = 2'd2,
    REQ_NONE     = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_MANY = 2'd1,
    ST_NO_FOR   = 2'd2,
    ST_UNUSED   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_EXEC
  } fsm_t;

  typedef struct packed {
    logic [1:0]                   req_type;
    logic [VAR_BITS-1:0]          var_id;
    logic signed [VALUE_BITS-1:0] start_value;
    logic signed [VALUE_BITS-1:0] end_value;
    logic signed [VALUE_BITS-1:0] step_value;
    logic [ADDR_BITS-1:0]         body_address;
    logic signed [VALUE_BITS-1:0] current_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic                         take_jump;
    logic [ADDR_BITS-1:0]         jump_address;
    logic                         write_var;
    logic [VAR_BITS-1:0]          var_id_out;
    logic signed [VALUE_BITS-1:0] new_value;
    logic [OUT_CNT_BITS-1:0]      active_loops;
  } out_item_t;

  typedef struct packed {
    logic [VAR_BITS-1:0]          var_id;
    logic signed [VALUE_BITS-1:0] end_value;
    logic signed [VALUE_BITS-1:0] step_value;
    logic [ADDR_BITS-1:0]         addr;
  } entry_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic [VAR_BITS-1:0] key;
    logic                shift_en;
    logic [CNT_BITS-1:0] shift_lo;
    logic [CNT_BITS-1:0] shift_hi;
    logic                wr_en;
    logic [POS_BITS-1:0] wr_idx;
    entry_t              wr_entry;
  } cell_ctrl_t;

endpackage

>>> rtl/fnls_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnls_cell: one slot of the loop stack
// Holds one entry, compares it against the search key, and either keeps it,
// takes the entry of the slot above, or loads a new entry.
// ----------------------------------------------------------------------------
module fnls_cell (
  input  logic                clk,
  input  logic [fnls_pkg::POS_BITS-1:0] idx,
  input  fnls_pkg::cell_ctrl_t ctrl,
  input  fnls_pkg::entry_t     upper,
  output fnls_pkg::entry_t     entry,
  output logic                 match
);
  import fnls_pkg::*;

  logic [CNT_BITS-1:0] pos;
  logic                do_shift;
  logic                do_write;

  assign pos      = CNT_BITS'(idx);
  assign do_shift = ctrl.shift_en && (pos >= ctrl.shift_lo) && (pos < ctrl.shift_hi);
  assign do_write = ctrl.wr_en && (idx == ctrl.wr_idx);
  assign match    = (entry.var_id == ctrl.key);

  always_ff @(posedge clk) begin
    if (do_write) begin
      entry <= ctrl.wr_entry;
    end else if (do_shift) begin
      entry <= upper;
    end
  end

endmodule

>>> rtl/for_next_loop_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// for_next_loop_stack: FOR/NEXT loop-control stack
// Chain of entry cells with a small sequencer doing search, loop test and
// stack update.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Its result appears on
// result with done high for one cycle, once the item has passed S_FIND and
// S_EXEC, and must be captured while done is high since there is no
// back-pressure. busy stays high through S_FIND and S_EXEC, so a new item can
// be taken in the cycle where done is shown, not before. S_FIND runs the
// top-down priority search over the cells, S_EXEC the signed compare and
// saturating add of the loop test and the shift/write of the cells.
module for_next_loop_stack (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  fnls_pkg::in_item_t  req,
  output logic                done,
  output fnls_pkg::out_item_t result
);
  import fnls_pkg::*;

  localparam logic signed [VALUE_BITS:0] SUM_MAX = {2'b00, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS:0] SUM_MIN = {2'b11, {(VALUE_BITS-1){1'b0}}};

  fsm_t                state, state_next;
  in_item_t            req_q;
  logic [CNT_BITS-1:0] count, count_next;
  logic                found_q;
  logic [POS_BITS-1:0] pos_q;
  entry_t              sel_q;

  entry_t              cell_entry [LOOP_DEPTH];
  logic [LOOP_DEPTH-1:0] cell_match;
  cell_ctrl_t          ctrl;

  logic                found;
  logic [POS_BITS-1:0] pos;

  out_item_t           res_next;
  logic                step_pos, step_neg, go;
  logic signed [VALUE_BITS:0] sum;
  logic signed [VALUE_BITS-1:0] sat_sum;

  // ---------------- cell chain ----------------
  for (genvar g = 0; g < LOOP_DEPTH; g++) begin : g_cell
    entry_t upper;
    if (g == LOOP_DEPTH - 1) begin : g_top
      assign upper = cell_entry[g];
    end else begin : g_mid
      assign upper = cell_entry[g + 1];
    end
    fnls_cell u_cell (
      .clk   (clk),
      .idx   (POS_BITS'(g)),
      .ctrl  (ctrl),
      .upper (upper),
      .entry (cell_entry[g]),
      .match (cell_match[g])
    );
  end

  // ---------------- search: top open slot for NEXT_TOP, else highest open slot that matches ----------------
  always_comb begin
    found = 1'b0;
    pos   = '0;
    if (req_q.req_type == REQ_NEXT_TOP) begin
      found = (count != '0);
      pos   = POS_BITS'(count - CNT_BITS'(1));
    end else begin
      for (int i = 0; i < LOOP_DEPTH; i++) begin
        if (cell_match[i] && (CNT_BITS'(i) < count)) begin
          found = 1'b1;
          pos   = POS_BITS'(i);
        end
      end
    end
  end

  // ---------------- loop test and saturating step ----------------
  always_comb begin
    step_pos = !sel_q.step_value[VALUE_BITS-1] && (sel_q.step_value != '0);
    step_neg = sel_q.step_value[VALUE_BITS-1];
    if (step_pos) begin
      go = $signed(req_q.current_value) < $signed(sel_q.end_value);
    end else if (step_neg) begin
      go = $signed(req_q.current_value) > $signed(sel_q.end_value);
    end else begin
      go = req_q.current_value != sel_q.end_value;
    end
    sum = $signed({req_q.current_value[VALUE_BITS-1], req_q.current_value})
        + $signed({sel_q.step_value[VALUE_BITS-1], sel_q.step_value});
    if (sum > SUM_MAX) begin
      sat_sum = SUM_MAX[VALUE_BITS-1:0];
    end else if (sum < SUM_MIN) begin
      sat_sum = SUM_MIN[VALUE_BITS-1:0];
    end else begin
      sat_sum = sum[VALUE_BITS-1:0];
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    count_next = count;
    res_next   = '0;
    ctrl       = '0;
    ctrl.key   = req_q.var_id;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_FIND;
        end
      end
      S_FIND: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
        case (req_q.req_type)
          REQ_FOR: begin
            if (!found_q && (count == CNT_BITS'(LOOP_DEPTH))) begin
              res_next.status = ST_TOO_MANY;
            end else begin
              // found entry rotates to the top, otherwise push a new one
              ctrl.shift_en = found_q;
              ctrl.shift_lo = CNT_BITS'(pos_q);
              ctrl.shift_hi = count - CNT_BITS'(1);
              ctrl.wr_en    = 1'b1;
              ctrl.wr_idx   = found_q ? POS_BITS'(count - CNT_BITS'(1))
                                      : POS_BITS'(count);
              ctrl.wr_entry.var_id     = req_q.var_id;
              ctrl.wr_entry.end_value  = req_q.end_value;
              ctrl.wr_entry.step_value = req_q.step_value;
              ctrl.wr_entry.addr       = req_q.body_address;
              if (!found_q) begin
                count_next = count + CNT_BITS'(1);
              end
              res_next.write_var  = 1'b1;
              res_next.var_id_out = req_q.var_id;
              res_next.new_value  = req_q.start_value;
            end
          end
          REQ_NEXT_TOP, REQ_NEXT_VAR: begin
            if (!found_q) begin
              res_next.status = ST_NO_FOR;
            end else if (go) begin
              res_next.take_jump    = 1'b1;
              res_next.jump_address = sel_q.addr;
              res_next.write_var    = 1'b1;
              res_next.var_id_out   = sel_q.var_id;
              res_next.new_value    = sat_sum;
            end else begin
              // drop the entry, slots above move down
              ctrl.shift_en = 1'b1;
              ctrl.shift_lo = CNT_BITS'(pos_q);
              ctrl.shift_hi = count - CNT_BITS'(1);
              count_next    = count - CNT_BITS'(1);
            end
          end
          default: begin
          end
        endcase
        res_next.active_loops = OUT_CNT_BITS'(count_next);
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= (state == S_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      req_q <= req;
    end
    if (state == S_FIND) begin
      found_q <= found;
      pos_q   <= pos;
      sel_q   <= cell_entry[pos];
    end
    if (state == S_EXEC) begin
      result <= res_next;
    end
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the for_next_loop_stack loop-control stack
// Sends FOR, NEXT and unused requests, keeps its own loop table to predict
// every result, and compares each done strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import fnls_pkg::*;

  localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
  localparam logic [31:0] MINV = 32'h8000_0000;
  localparam int CYCLE_LIMIT = 200000;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  in_item_t  req;
  logic      done;
  out_item_t result;

  for_next_loop_stack dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
  );

  // predicted loop table
  entry_t    loop_tab [LOOP_DEPTH];
  int        open_loops = 0;
  out_item_t expected_loop_results [$];
  int        errors = 0;
  int        cycle_count = 0;
  bit        no_gaps = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int find_open(logic [VAR_BITS-1:0] v);
    for (int i = open_loops - 1; i >= 0; i--) begin
      if (loop_tab[i].var_id == v) return i;
    end
    return -1;
  endfunction

  function automatic out_item_t predict_loop_request(in_item_t it);
    out_item_t r;
    int        pos;
    entry_t    held;
    logic      go;
    longint    sum;
    r = '0;
    r.status = ST_OK;
    case (req_type_t'(it.req_type))
      REQ_FOR: begin
        pos = find_open(it.var_id);
        if (pos < 0) begin
          if (open_loops >= LOOP_DEPTH) begin
            r.status = ST_TOO_MANY;
          end else begin
            pos = open_loops;
            open_loops++;
            loop_tab[pos].var_id = it.var_id;
          end
        end else begin
          // rotate the found entry to the top
          held = loop_tab[pos];
          for (int i = pos; i + 1 < open_loops; i++) loop_tab[i] = loop_tab[i + 1];
          pos = open_loops - 1;
          loop_tab[pos] = held;
        end
        if (r.status == ST_OK) begin
          loop_tab[pos].end_value  = it.end_value;
          loop_tab[pos].step_value = it.step_value;
          loop_tab[pos].addr       = it.body_address;
          r.write_var  = 1'b1;
          r.var_id_out = it.var_id;
          r.new_value  = it.start_value;
        end
      end
      REQ_NEXT_TOP, REQ_NEXT_VAR: begin
        pos = (it.req_type == REQ_NEXT_TOP) ? open_loops - 1 : find_open(it.var_id);
        if (pos < 0) begin
          r.status = ST_NO_FOR;
        end else begin
          go = ($signed(loop_tab[pos].step_value) > 0 &&
                $signed(it.current_value) < $signed(loop_tab[pos].end_value)) ||
               ($signed(loop_tab[pos].step_value) < 0 &&
                $signed(it.current_value) > $signed(loop_tab[pos].end_value)) ||
               (loop_tab[pos].step_value == 0 &&
                it.current_value != loop_tab[pos].end_value);
          if (go) begin
            sum = longint'($signed(it.current_value)) +
                  longint'($signed(loop_tab[pos].step_value));
            r.take_jump    = 1'b1;
            r.jump_address = loop_tab[pos].addr;
            r.write_var    = 1'b1;
            r.var_id_out   = loop_tab[pos].var_id;
            if (sum > 64'sd2147483647) r.new_value = MAXV;
            else if (sum < -64'sd2147483648) r.new_value = MINV;
            else r.new_value = sum[31:0];
          end else begin
            for (int i = pos; i + 1 < open_loops; i++) loop_tab[i] = loop_tab[i + 1];
            open_loops--;
          end
        end
      end
      default: ;
    endcase
    r.active_loops = open_loops[OUT_CNT_BITS-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h, expected %0h (cycle %0d)", what, got, want,
             cycle_count);
    errors++;
  endtask

  task automatic check_result(out_item_t got, out_item_t want);
    if (got.status !== want.status) report_mismatch("status", got.status, want.status);
    if (got.take_jump !== want.take_jump)
      report_mismatch("take_jump", got.take_jump, want.take_jump);
    if (got.jump_address !== want.jump_address)
      report_mismatch("jump_address", got.jump_address, want.jump_address);
    if (got.write_var !== want.write_var)
      report_mismatch("write_var", got.write_var, want.write_var);
    if (got.var_id_out !== want.var_id_out)
      report_mismatch("var_id_out", got.var_id_out, want.var_id_out);
    if (got.new_value !== want.new_value)
      report_mismatch("new_value", got.new_value, want.new_value);
    if (got.active_loops !== want.active_loops)
      report_mismatch("active_loops", got.active_loops, want.active_loops);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_loop_results.size() == 0) report_mismatch("unexpected result", 0, 0);
      else check_result(result, expected_loop_results.pop_front());
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    start <= 1'b1;
    req   <= it;
    do @(posedge clk); while (busy);
    expected_loop_results.push_back(predict_loop_request(it));
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return MAXV;
      1: return MINV;
      2: return 32'd0;
      3, 4: return $urandom;
      default: return ($urandom_range(0, 2000) - 1000) <<< 12;
    endcase
  endfunction

  function automatic in_item_t make_request(req_type_t t, logic [7:0] v,
                                            logic [31:0] sv, logic [31:0] ev,
                                            logic [31:0] stp, logic [15:0] addr,
                                            logic [31:0] cur);
    in_item_t it;
    it.req_type      = t;
    it.var_id        = v;
    it.start_value   = sv;
    it.end_value     = ev;
    it.step_value    = stp;
    it.body_address  = addr;
    it.current_value = cur;
    return it;
  endfunction

  function automatic in_item_t rand_item(req_type_t t);
    return make_request(t, 8'($urandom_range(0, 255)), pick_value(), pick_value(),
                        pick_value(), 16'($urandom_range(0, 65535)), pick_value());
  endfunction

  // value of the loop variable near its limit, so loops both repeat and end
  function automatic logic [31:0] value_near_end(entry_t e);
    case ($urandom_range(0, 5))
      0, 1: return e.end_value;
      2: return e.end_value - e.step_value * $urandom_range(1, 3);
      3: return e.end_value + e.step_value;
      4: return e.end_value - e.step_value;
      default: return pick_value();
    endcase
  endfunction

  task automatic test_basic_requests();
    send_item(make_request(REQ_NEXT_TOP, 8'd0, 0, 0, 0, 16'h0000, 0));
    send_item(make_request(REQ_NEXT_VAR, 8'd5, 0, 0, 0, 16'h0000, 0));
    send_item(make_request(REQ_NONE, 8'hFF, MAXV, MINV, MAXV, 16'hFFFF, MINV));
    send_item(make_request(REQ_FOR, 8'd0, MINV, MAXV, 32'h0001_0000, 16'h0000, 0));
    send_item(make_request(REQ_FOR, 8'hFF, MAXV, MINV, 32'hFFFF_0000, 16'hFFFF, 0));
    send_item(make_request(REQ_FOR, 8'd7, 0, 0, 0, 16'h1234, 0));
    // zero step loops while the value differs from the limit
    send_item(make_request(REQ_NEXT_TOP, 8'd0, 0, 0, 0, 16'h0000, 32'd5));
    send_item(make_request(REQ_NEXT_TOP, 8'd0, 0, 0, 0, 16'h0000, 32'd0));
    send_item(make_request(REQ_NEXT_VAR, 8'd0, 0, 0, 0, 16'h0000, 32'h7FFF_8000));
    // leaving the bottom loop shifts the one above down
    send_item(make_request(REQ_NEXT_VAR, 8'd0, 0, 0, 0, 16'h0000, MAXV));
    send_item(make_request(REQ_FOR, 8'd0, 0, 32'h000A_0000, MAXV, 16'h8000, 0));
    send_item(make_request(REQ_FOR, 8'hFF, 0, MINV, MINV, 16'h00FF, 0));
    send_item(make_request(REQ_NEXT_VAR, 8'hFF, 0, 0, 0, 16'h0000, 32'hFFFF_FFFB));
    send_item(make_request(REQ_NEXT_VAR, 8'd99, 0, 0, 0, 16'h0000, 0));
    send_item(make_request(REQ_NEXT_VAR, 8'd0, 0, 0, 0, 16'h0000, 32'd1));
    send_item(make_request(REQ_NEXT_TOP, 8'd0, 0, 0, 0, 16'h0000, MINV));
    send_item(make_request(REQ_NONE, 8'd0, 0, 0, 0, 16'h0000, 0));
    send_item(make_request(REQ_FOR, 8'd0, 32'h0005_0000, 32'hFFFB_0000, 32'hFFFF_0000,
                           16'h5555, 0));
    send_item(make_request(REQ_NEXT_TOP, 8'd0, 0, 0, 0, 16'h0000, 32'hFFFA_0000));
    send_item(make_request(REQ_NEXT_TOP, 8'hAA, MAXV, MAXV, MAXV, 16'hAAAA, MAXV));
  endtask

  task automatic test_table_full();
    for (int i = 0; i < LOOP_DEPTH; i++) begin
      send_item(make_request(REQ_FOR, 8'(100 + i), pick_value(), pick_value(), pick_value(),
                             16'($urandom_range(0, 65535)), pick_value()));
    end
    send_item(rand_item(REQ_FOR));
    send_item(make_request(REQ_FOR, 8'd116, pick_value(), 0, 0, 16'h0001, 0));
    send_item(make_request(REQ_FOR, 8'd105, pick_value(), 0, 32'h0001_0000, 16'h0002, 0));
    send_item(make_request(REQ_NEXT_VAR, 8'd110, 0, 0, 0, 16'h0000,
                           loop_tab[find_open(8'd110)].end_value));
    send_item(make_request(REQ_FOR, 8'd117, pick_value(), 0, 0, 16'h0003, 0));
    send_item(make_request(REQ_FOR, 8'd118, pick_value(), 0, 0, 16'h0004, 0));
    while (open_loops > 0) begin
      send_item(make_request(REQ_NEXT_TOP, 8'($urandom_range(0, 255)), 0, 0, 0, 16'h0000,
                             loop_tab[open_loops - 1].end_value));
    end
    send_item(make_request(REQ_NEXT_TOP, 8'd0, 0, 0, 0, 16'h0000, 0));
  endtask

  task automatic test_noise();
    for (int n = 0; n < 30; n++) send_item(rand_item(req_type_t'($urandom_range(0, 3))));
  endtask

  task automatic test_random_loops();
    in_item_t    it;
    int          r;
    int          pos;
    logic [31:0] stp;
    for (int n = 0; n < 380; n++) begin
      if (n % 60 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      if (r < 35) begin
        it = rand_item(REQ_FOR);
        if ($urandom_range(0, 9) != 0) it.var_id = 8'($urandom_range(0, 19));
        case ($urandom_range(0, 3))
          0: stp = $urandom_range(1, 4) <<< 16;
          1: stp = -($urandom_range(1, 4) <<< 16);
          2: stp = 32'd0;
          default: stp = pick_value();
        endcase
        it.step_value = stp;
        if ($urandom_range(0, 3) != 0)
          it.end_value = it.start_value + stp * $urandom_range(0, 5);
      end else if (r < 65) begin
        it = rand_item(REQ_NEXT_TOP);
        if (open_loops > 0) it.current_value = value_near_end(loop_tab[open_loops - 1]);
      end else if (r < 90) begin
        it = rand_item(REQ_NEXT_VAR);
        if (open_loops > 0) begin
          pos = $urandom_range(0, open_loops - 1);
          it.var_id = loop_tab[pos].var_id;
          it.current_value = value_near_end(loop_tab[pos]);
        end
      end else if (r < 96) begin
        it = rand_item(REQ_NEXT_VAR);
      end else begin
        it = rand_item(REQ_NONE);
      end
      send_item(it);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst   = 1'b1;
    start = 1'b0;
    req   = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_requests();
    test_table_full();
    test_noise();
    test_random_loops();
    start <= 1'b0;
    while (expected_loop_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/fnls_pkg.sv
rtl/fnls_cell.sv
rtl/for_next_loop_stack.sv
dv/tb.sv
